// ===== src/uvs_pkg.sv =====
`default_nettype none

package uvs_pkg;

  localparam int MAX_SLICES_DEF = 256;
  localparam int MAX_STACKS_DEF = 256;

  // Angle phase, one full turn is 2^PHASE_W
  localparam int PHASE_W = 24;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1 << (PHASE_W - 2));

  // Quotient bits of the two phase dividers and of the texture taps
  localparam int THETA_FRAC = 24;
  localparam int PHI_FRAC   = 23;
  localparam int TEX_FRAC   = 16;
  localparam int DIV_STEP   = 4;
  localparam int DIV_LAT    = (THETA_FRAC + DIV_STEP - 1) / DIV_STEP + 1;

  // Q30 trig
  localparam int Q30_W = 31;
  localparam logic [Q30_W-1:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [Q30_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int HORNER_N = 5;
  localparam logic [6:0] HORNER_DIV [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [29:0] HORNER_RCP [HORNER_N] = '{
    30'(64'd4294967296 / 110),
    30'(64'd4294967296 / 72),
    30'(64'd4294967296 / 42),
    30'(64'd4294967296 / 20),
    30'(64'd4294967296 / 6)
  };
  localparam int SIN_LAT = 3 + 3 * HORNER_N + 1;

  typedef enum logic [1:0] {
    CFG_RADIUS      = 2'd0,
    CFG_SLICE_COUNT = 2'd1,
    CFG_STACK_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } res_t;

endpackage

`default_nettype wire

// ===== src/uvs_if.sv =====
`default_nettype none

interface uvs_coord_if;
  logic       valid;
  logic       ready;
  logic [8:0] ring;
  logic [8:0] slice;

  modport source (output valid, ring, slice, input ready);
  modport sink   (input valid, ring, slice, output ready);
endinterface

interface uvs_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tangent_x, tangent_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tangent_x, tangent_z, tex_u, tex_v, output ready);
endinterface

`default_nettype wire

// ===== src/uv_sphere_vertex_generator_unit.sv =====
`default_nettype none
// Throughput: one vertex per cycle while the output buffer has room; set by the fully pipelined dividers
// (four quotient bits per stage) and the four parallel sine pipelines.
// Reset (rst, synchronous, active high) empties the pipeline and the output
// buffer and loads radius 1.0, 20 slices and 20 stacks.
module uv_sphere_vertex_generator_unit
  import uvs_pkg::*;
#(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int MAX_STACKS = MAX_STACKS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  uvs_coord_if.sink        coord,
  uvs_vertex_if.source     vertex,
  input  wire              wr_en,
  input  wire [1:0]        wr_index,
  input  wire [14:0]       wr_data
);

  localparam int SW = $clog2(MAX_SLICES + 1);
  localparam int KW = $clog2(MAX_STACKS + 1);
  localparam int AW = (SW > 9) ? SW : 9;
  localparam int BW = (KW > 9) ? KW : 9;

  // Counts are kept already clamped to their legal range.
  function automatic logic [SW-1:0] clamp_slices(input logic [8:0] v);
    logic [AW-1:0] e;
    e = AW'(v);
    if (e < AW'(3)) e = AW'(3);
    if (e > AW'(MAX_SLICES)) e = AW'(MAX_SLICES);
    return SW'(e);
  endfunction

  function automatic logic [KW-1:0] clamp_stacks(input logic [8:0] v);
    logic [BW-1:0] e;
    e = BW'(v);
    if (e < BW'(2)) e = BW'(2);
    if (e > BW'(MAX_STACKS)) e = BW'(MAX_STACKS);
    return KW'(e);
  endfunction

  // Q30 magnitude to Q1.14, rounded and clamped to one
  function automatic logic signed [15:0] to_q14(input logic [Q30_W-1:0] m, input logic n);
    logic [31:0] sum;
    logic [15:0] q;
    sum = {1'b0, m} + 32'd32768;
    q   = sum[31:16];
    if (q > 16'd16384) q = 16'd16384;
    return n ? -$signed(q) : $signed(q);
  endfunction

  // radius times a Q30 component, rounded, clamped to the Q8.8 range
  function automatic logic signed [15:0] to_pos(input logic [14:0] rad,
                                                input logic [Q30_W-1:0] m, input logic n);
    logic [46:0] prod;
    logic [16:0] q;
    prod = 47'(rad) * 47'(m) + 47'd536870912;
    q    = prod[46:30];
    if (q > 17'd32767) q = 17'd32767;
    return n ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration. The user must write only while no transaction is in flight;
  // the block does not enforce it, and every stage reads these registers directly.
  // ---------------------------------------------------------------------
  logic [14:0]   radius;
  logic [SW-1:0] slices;
  logic [KW-1:0] stacks;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 15'd256;
      slices <= clamp_slices(9'd20);
      stacks <= clamp_stacks(9'd20);
    end else if (wr_en) begin
      case (wr_index)
        CFG_RADIUS:      radius <= wr_data;
        CFG_SLICE_COUNT: slices <= clamp_slices(wr_data[8:0]);
        CFG_STACK_COUNT: stacks <= clamp_stacks(wr_data[8:0]);
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: every stage advances together whenever the output
  // buffer can take what leaves the last stage.
  // ---------------------------------------------------------------------
  logic advance;
  logic push;
  res_t p2_res;
  logic p2_vld;
  res_t head;
  logic head_valid;

  assign coord.ready = advance;
  assign push        = advance && p2_vld;

  // ---------------------------------------------------------------------
  // Stage 0: clamp ring and slice, flag the poles.
  // ---------------------------------------------------------------------
  logic [AW-1:0] j_ext;
  logic [BW-1:0] i_ext;
  logic [AW-1:0] j_sat;
  logic [BW-1:0] i_sat;

  assign j_ext = AW'(coord.slice);
  assign i_ext = BW'(coord.ring);
  assign j_sat = (j_ext > AW'(slices)) ? AW'(slices) : j_ext;
  assign i_sat = (i_ext > BW'(stacks)) ? BW'(stacks) : i_ext;

  logic          s0_vld;
  logic          s0_top;
  logic          s0_bot;
  logic [SW-1:0] s0_j;
  logic [KW-1:0] s0_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (advance) begin
      s0_vld <= coord.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_j   <= SW'(j_sat);
      s0_i   <= KW'(i_sat);
      s0_top <= (i_sat == '0);
      s0_bot <= (i_sat == BW'(stacks));
    end
  end

  // ---------------------------------------------------------------------
  // Dividers: theta phase j*2^24/slices with tex_u tapped at 16 bits,
  // phi phase i*2^23/stacks with tex_v tapped at 16 bits.
  // ---------------------------------------------------------------------
  logic [THETA_FRAC:0] theta_q;
  logic [TEX_FRAC:0]   tex_u_q;
  logic [PHI_FRAC:0]   phi_q;
  logic [TEX_FRAC:0]   tex_v_q;

  uvs_div_pipe #(.DW(SW), .FRAC(THETA_FRAC), .TAP(TEX_FRAC)) u_div_theta (
    .clk     (clk),
    .advance (advance),
    .num     (s0_j),
    .den     (slices),
    .quo     (theta_q),
    .tap     (tex_u_q)
  );

  uvs_div_pipe #(.DW(KW), .FRAC(PHI_FRAC), .TAP(TEX_FRAC)) u_div_phi (
    .clk     (clk),
    .advance (advance),
    .num     (s0_i),
    .den     (stacks),
    .quo     (phi_q),
    .tap     (tex_v_q)
  );

  // pole flags and valid bits ride along with the dividers
  typedef struct packed {
    logic vld;
    logic top;
    logic bot;
  } pole_t;

  typedef struct packed {
    logic        vld;
    logic        top;
    logic        bot;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  pole_t dline [DIV_LAT];
  side_t sline [SIN_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < DIV_LAT; n++) begin
        dline[n] <= '0;
      end
      for (int n = 0; n < SIN_LAT; n++) begin
        sline[n] <= '0;
      end
    end else if (advance) begin
      dline[0] <= '{vld: s0_vld, top: s0_top, bot: s0_bot};
      for (int n = 1; n < DIV_LAT; n++) begin
        dline[n] <= dline[n-1];
      end
      sline[0] <= '{vld: dline[DIV_LAT-1].vld, top: dline[DIV_LAT-1].top,
                    bot: dline[DIV_LAT-1].bot, tex_u: tex_u_q, tex_v: tex_v_q};
      for (int n = 1; n < SIN_LAT; n++) begin
        sline[n] <= sline[n-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Four sine pipelines; cosine is the sine a quarter turn on.
  // ---------------------------------------------------------------------
  logic [PHASE_W-1:0] ph_theta;
  logic [PHASE_W-1:0] ph_phi;
  logic [PHASE_W-1:0] ph_theta_c;
  logic [PHASE_W-1:0] ph_phi_c;

  assign ph_theta   = theta_q[PHASE_W-1:0];
  assign ph_phi     = PHASE_W'(phi_q);
  assign ph_theta_c = ph_theta + QUARTER_TURN;
  assign ph_phi_c   = ph_phi + QUARTER_TURN;

  logic [Q30_W-1:0] st_mag, ct_mag, sp_mag, cp_mag;
  logic             st_neg, ct_neg, sp_neg, cp_neg;

  uvs_sin_pipe u_sin_theta (
    .clk(clk), .advance(advance), .phase(ph_theta), .mag(st_mag), .neg(st_neg)
  );
  uvs_sin_pipe u_cos_theta (
    .clk(clk), .advance(advance), .phase(ph_theta_c), .mag(ct_mag), .neg(ct_neg)
  );
  uvs_sin_pipe u_sin_phi (
    .clk(clk), .advance(advance), .phase(ph_phi), .mag(sp_mag), .neg(sp_neg)
  );
  uvs_sin_pipe u_cos_phi (
    .clk(clk), .advance(advance), .phase(ph_phi_c), .mag(cp_mag), .neg(cp_neg)
  );

  // ---------------------------------------------------------------------
  // P1: normal x and z as sin(phi) times cos/sin(theta), rounded.
  // ---------------------------------------------------------------------
  logic [61:0] nx_prod;
  logic [61:0] nz_prod;

  assign nx_prod = 62'(sp_mag) * 62'(ct_mag) + 62'd536870912;
  assign nz_prod = 62'(sp_mag) * 62'(st_mag) + 62'd536870912;

  side_t            p1_side;
  logic [Q30_W-1:0] p1_nx_mag, p1_nz_mag, p1_cp_mag, p1_st_mag, p1_ct_mag;
  logic             p1_nx_neg, p1_nz_neg, p1_cp_neg, p1_st_neg, p1_ct_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_side <= '0;
    end else if (advance) begin
      p1_side <= sline[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_nx_mag <= nx_prod[60:30];
      p1_nz_mag <= nz_prod[60:30];
      p1_nx_neg <= sp_neg ^ ct_neg;
      p1_nz_neg <= sp_neg ^ st_neg;
      p1_cp_mag <= cp_mag;
      p1_cp_neg <= cp_neg;
      p1_st_mag <= st_mag;
      p1_st_neg <= st_neg;
      p1_ct_mag <= ct_mag;
      p1_ct_neg <= ct_neg;
    end
  end

  // ---------------------------------------------------------------------
  // P2: scale by radius, convert to Q1.14, substitute the poles.
  // ---------------------------------------------------------------------
  res_t vtx;

  always_comb begin
    vtx.pos_x     = to_pos(radius, p1_nx_mag, p1_nx_neg);
    vtx.pos_y     = to_pos(radius, p1_cp_mag, p1_cp_neg);
    vtx.pos_z     = to_pos(radius, p1_nz_mag, p1_nz_neg);
    vtx.normal_x  = to_q14(p1_nx_mag, p1_nx_neg);
    vtx.normal_y  = to_q14(p1_cp_mag, p1_cp_neg);
    vtx.normal_z  = to_q14(p1_nz_mag, p1_nz_neg);
    vtx.tangent_x = to_q14(p1_st_mag, !p1_st_neg);
    vtx.tangent_z = to_q14(p1_ct_mag, p1_ct_neg);
    vtx.tex_u     = p1_side.tex_u;
    vtx.tex_v     = p1_side.tex_v;
    if (p1_side.top || p1_side.bot) begin
      // poles ignore the slice: straight up or down, tangent along +x
      vtx.pos_x     = '0;
      vtx.pos_z     = '0;
      vtx.normal_x  = '0;
      vtx.normal_z  = '0;
      vtx.tangent_x = 16'sd16384;
      vtx.tangent_z = '0;
      vtx.tex_u     = '0;
      if (p1_side.top) begin
        vtx.pos_y    = $signed({1'b0, radius});
        vtx.normal_y = 16'sd16384;
        vtx.tex_v    = '0;
      end else begin
        vtx.pos_y    = -$signed({1'b0, radius});
        vtx.normal_y = -16'sd16384;
        vtx.tex_v    = 17'd65536;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (advance) begin
      p2_vld <= p1_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_res <= vtx;
    end
  end

  // ---------------------------------------------------------------------
  // Output buffer
  // ---------------------------------------------------------------------
  uvs_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (p2_res),
    .pop_ready  (vertex.ready),
    .head       (head),
    .head_valid (head_valid),
    .room       (advance)
  );

  assign vertex.valid     = head_valid;
  assign vertex.pos_x     = head.pos_x;
  assign vertex.pos_y     = head.pos_y;
  assign vertex.pos_z     = head.pos_z;
  assign vertex.normal_x  = head.normal_x;
  assign vertex.normal_y  = head.normal_y;
  assign vertex.normal_z  = head.normal_z;
  assign vertex.tangent_x = head.tangent_x;
  assign vertex.tangent_z = head.tangent_z;
  assign vertex.tex_u     = head.tex_u;
  assign vertex.tex_v     = head.tex_v;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // input stalls only behind a full buffer whose head is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !coord.ready |-> (vertex.valid && !vertex.ready))
    else $error("input stalled without a blocked output");

  // only the top pole has v of zero, and it points straight up
  a_top_pole: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.tex_v == 17'd0) |->
      (vertex.normal_y == 16'sd16384 && vertex.pos_x == 16'sd0 &&
       vertex.tangent_x == 16'sd16384))
    else $error("top pole vertex malformed");

  // normal x and tangent z never exceed one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    vertex.valid |->
      (vertex.normal_x <= 16'sd16384 && vertex.normal_x >= -16'sd16384 &&
       vertex.tangent_z <= 16'sd16384 && vertex.tangent_z >= -16'sd16384))
    else $error("unit component out of range");

endmodule

`default_nettype wire

// ===== src/uvs_div_pipe.sv =====
`default_nettype none

// Pipelined restoring division of num/den with num <= den, DIV_STEP
// quotient bits per stage, rounded to nearest at the end.
module uvs_div_pipe
  import uvs_pkg::*;
#(
  parameter int DW   = 9,
  parameter int FRAC = 24,
  parameter int TAP  = 16
) (
  input  wire            clk,
  input  wire            advance,
  input  wire [DW-1:0]   num,
  input  wire [DW-1:0]   den,
  output logic [FRAC:0]  quo,
  output logic [TAP:0]   tap
);

  localparam int NST = (FRAC + DIV_STEP - 1) / DIV_STEP;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [DW-1:0] rem;
    logic [FRAC:0] quo;
    logic [DW-1:0] trem;
    logic [TAP:0]  tquo;
  } dst_t;

  dst_t st [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    dst_t src;
    dst_t cur;

    if (g == 0) begin : g_head
      always_comb begin
        src.den  = den;
        src.quo  = (FRAC + 1)'(num == den);
        src.rem  = (num == den) ? '0 : num;
        src.trem = '0;
        src.tquo = '0;
      end
    end else begin : g_body
      assign src = st[g-1];
    end

    always_comb begin
      logic [DW:0] dbl;
      dbl = '0;
      cur = src;
      for (int t = 0; t < DIV_STEP; t++) begin
        if (g * DIV_STEP + t < FRAC) begin
          dbl = {cur.rem, 1'b0};
          if (dbl >= {1'b0, cur.den}) begin
            cur.rem = DW'(dbl - {1'b0, cur.den});
            cur.quo = {cur.quo[FRAC-1:0], 1'b1};
          end else begin
            cur.rem = dbl[DW-1:0];
            cur.quo = {cur.quo[FRAC-1:0], 1'b0};
          end
          if (g * DIV_STEP + t + 1 == TAP) begin
            cur.tquo = cur.quo[TAP:0];
            cur.trem = cur.rem;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[g] <= cur;
      end
    end
  end

  // Round to nearest: bump when the remainder reaches half the divisor
  logic [DW:0] half_den;
  logic [DW:0] qsum;
  logic [DW:0] tsum;

  assign half_den = {2'b0, st[NST-1].den[DW-1:1]};
  assign qsum     = {1'b0, st[NST-1].rem} + half_den;
  assign tsum     = {1'b0, st[NST-1].trem} + half_den;

  always_ff @(posedge clk) begin
    if (advance) begin
      quo <= st[NST-1].quo + (FRAC + 1)'(qsum >= {1'b0, st[NST-1].den});
      tap <= st[NST-1].tquo + (TAP + 1)'(tsum >= {1'b0, st[NST-1].den});
    end
  end

endmodule

`default_nettype wire

// ===== src/uvs_sin_pipe.sv =====
`default_nettype none

// Sine of a phase in Q30, sign and magnitude, by quadrant folding and
// a six-term Horner series.
module uvs_sin_pipe
  import uvs_pkg::*;
(
  input  wire                clk,
  input  wire                advance,
  input  wire [PHASE_W-1:0]  phase,
  output logic [Q30_W-1:0]   mag,
  output logic               neg
);

  localparam int PH_Q = PHASE_W - 2;
  localparam logic [PH_Q:0] QTR = {1'b1, {PH_Q{1'b0}}};

  // fold into the first quadrant
  logic [PH_Q:0] f_r;
  logic          f_neg;

  always_ff @(posedge clk) begin
    if (advance) begin
      f_neg <= phase[PHASE_W-1];
      if (phase[PHASE_W-2]) begin
        f_r <= QTR - {1'b0, phase[PH_Q-1:0]};
      end else begin
        f_r <= {1'b0, phase[PH_Q-1:0]};
      end
    end
  end

  // angle in Q30 radians
  logic [53:0]      x_prod;
  logic [Q30_W-1:0] x_x;
  logic             x_neg;

  assign x_prod = 54'(f_r) * 54'(HALF_PI_Q30) + 54'd2097152;

  always_ff @(posedge clk) begin
    if (advance) begin
      x_x   <= x_prod[52:22];
      x_neg <= f_neg;
    end
  end

  // square
  logic [61:0]      sq;
  logic [Q30_W-1:0] s_x;
  logic [31:0]      s_x2;
  logic             s_neg;

  assign sq = 62'(x_x) * 62'(x_x);

  always_ff @(posedge clk) begin
    if (advance) begin
      s_x   <= x_x;
      s_x2  <= sq[61:30];
      s_neg <= x_neg;
    end
  end

  logic [Q30_W-1:0] a_x  [HORNER_N];
  logic [31:0]      a_x2 [HORNER_N];
  logic [31:0]      a_p  [HORNER_N];
  logic             a_neg[HORNER_N];
  logic [Q30_W-1:0] b_x  [HORNER_N];
  logic [31:0]      b_x2 [HORNER_N];
  logic [31:0]      b_p  [HORNER_N];
  logic [29:0]      b_qe [HORNER_N];
  logic             b_neg[HORNER_N];
  logic [Q30_W-1:0] c_x  [HORNER_N];
  logic [31:0]      c_x2 [HORNER_N];
  logic [Q30_W-1:0] c_t  [HORNER_N];
  logic             c_neg[HORNER_N];

  for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
    logic [Q30_W-1:0] in_x;
    logic [31:0]      in_x2;
    logic [Q30_W-1:0] in_t;
    logic             in_neg;
    logic [62:0]      pa;
    logic [61:0]      pb;
    logic [31:0]      qd;
    logic [31:0]      rem;
    logic [Q30_W-1:0] qv;

    if (k == 0) begin : g_first
      assign in_x   = s_x;
      assign in_x2  = s_x2;
      assign in_t   = Q30_ONE;
      assign in_neg = s_neg;
    end else begin : g_next
      assign in_x   = c_x[k-1];
      assign in_x2  = c_x2[k-1];
      assign in_t   = c_t[k-1];
      assign in_neg = c_neg[k-1];
    end

    // x2 * t
    assign pa = 63'(in_x2) * 63'(in_t);
    // divide by the series constant through its reciprocal
    assign pb = 62'(a_p[k]) * 62'(HORNER_RCP[k]);
    // the estimate is low by at most one
    assign qd  = 32'(b_qe[k]) * 32'(HORNER_DIV[k]);
    assign rem = b_p[k] - qd;
    assign qv  = Q30_W'(b_qe[k]) + Q30_W'(rem >= 32'(HORNER_DIV[k]));

    always_ff @(posedge clk) begin
      if (advance) begin
        a_x[k]   <= in_x;
        a_x2[k]  <= in_x2;
        a_p[k]   <= pa[61:30];
        a_neg[k] <= in_neg;
        b_x[k]   <= a_x[k];
        b_x2[k]  <= a_x2[k];
        b_p[k]   <= a_p[k];
        b_qe[k]  <= pb[61:32];
        b_neg[k] <= a_neg[k];
        c_x[k]   <= b_x[k];
        c_x2[k]  <= b_x2[k];
        c_t[k]   <= Q30_ONE - qv;
        c_neg[k] <= b_neg[k];
      end
    end
  end

  logic [61:0] pf;
  assign pf = 62'(c_x[HORNER_N-1]) * 62'(c_t[HORNER_N-1]);

  always_ff @(posedge clk) begin
    if (advance) begin
      mag <= pf[60:30];
      neg <= c_neg[HORNER_N-1];
    end
  end

endmodule

`default_nettype wire

// ===== src/uvs_out_buf.sv =====
`default_nettype none

// Two-entry output buffer; keeps the pipeline moving while one result waits.
module uvs_out_buf
  import uvs_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire res_t  push_data,
  input  wire        pop_ready,
  output res_t       head,
  output logic       head_valid,
  output logic       room
);

  res_t       e1;
  logic [1:0] cnt;
  logic       pop;

  assign head_valid = (cnt != 2'd0);
  assign pop        = head_valid && pop_ready;
  assign room       = (cnt != 2'd2) || pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            head <= push_data;
          end else begin
            e1 <= push_data;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          head <= e1;
          cnt  <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            head <= push_data;
          end else begin
            head <= e1;
            e1   <= push_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && push) |-> pop_ready)
    else $error("output buffer overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> head_valid)
    else $error("pushed transaction not visible at the head");

endmodule

`default_nettype wire
